// ===== hw/rtl/mse_pkg.sv =====
package mse_pkg;

    // Element width and default capacity
    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    // One element on a link of the chain, with its occupancy bit
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } mse_beat_t;

endpackage

// ===== hw/rtl/merge_sort_engine_unit.sv =====
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// input    | value, is_last                          | beat taken when start && !busy
// result   | sorted_value, end_of_set, overflowed    | result_valid with each element
//
// Loading takes a beat whenever busy is low. After the closing beat the chain settles
// while elements travel on cell by cell, then unloads one element per cycle from
// cell 0. Reset empties every cell; no clearing pass is needed.
// The receiver cannot stall; busy is high after the closing beat until the last result.
module merge_sort_engine_unit #(
    parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [mse_pkg::DATA_W-1:0] value,
    input  logic                              is_last,
    output logic                              busy,
    output logic                              result_valid,
    output logic signed [mse_pkg::DATA_W-1:0] sorted_value,
    output logic                              end_of_set,
    output logic                              overflowed
);
    import mse_pkg::*;

    localparam int            CW  = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic                     drop_reg;
    logic                     drop_next;
    logic                     inj_valid_reg;
    logic                     inj_valid_next;
    logic signed [DATA_W-1:0] inj_data_reg;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic                     res_end_reg;
    logic                     res_end_next;
    logic                     res_ovf_reg;
    logic                     res_ovf_next;
    logic signed [DATA_W-1:0] res_data_reg;
    logic                     accept;
    logic                     shift;
    logic                     emit_last;

    mse_beat_t fwd  [MAX_ELEMENTS+1];
    mse_beat_t held [MAX_ELEMENTS+1];

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_LOAD);
    assign shift     = (state_reg == ST_EMIT);
    assign emit_last = (cnt_reg == count_reg - CW'(1));

    // Sorting chain
    assign fwd[0].valid               = inj_valid_reg;
    assign fwd[0].data                = inj_data_reg;
    assign held[MAX_ELEMENTS].valid   = 1'b0;
    assign held[MAX_ELEMENTS].data    = '0;

    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        mse_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (shift),
            .left_fwd   (fwd[i]),
            .right_held (held[i+1]),
            .fwd        (fwd[i+1]),
            .held       (held[i])
        );
    end

    // Sequencer: load, settle, unload
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        inj_valid_next = 1'b0;
        res_valid_next = 1'b0;
        res_end_next   = 1'b0;
        res_ovf_next   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CAP)
                    begin
                        inj_valid_next = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_SETTLE;
                        cnt_next   = '0;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (cnt_reg == CAP)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                res_end_next   = emit_last;
                res_ovf_next   = emit_last && drop_reg;
                if (emit_last)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    drop_next  = 1'b0;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            inj_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_end_reg   <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            inj_valid_reg <= inj_valid_next;
            res_valid_reg <= res_valid_next;
            res_end_reg   <= res_end_next;
            res_ovf_reg   <= res_ovf_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        inj_data_reg <= value;
        res_data_reg <= held[0].data;
    end

    assign result_valid = res_valid_reg;
    assign sorted_value = res_data_reg;
    assign end_of_set   = res_end_reg;
    assign overflowed   = res_ovf_reg;

`ifndef SYNTH
    // No element ever travels off the end of the chain
    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !fwd[MAX_ELEMENTS].valid)
        else $error("element left the end of the sorting chain");

    // Cell 0 holds an element on every unload cycle
    a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> held[0].valid)
        else $error("unloading from an empty chain");

    // The closing result returns the block to loading
    a_end_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_set) |-> (state_reg == ST_LOAD))
        else $error("set closed but block still busy");

    // Overflow is only flagged on the closing result
    a_ovf_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed |-> (result_valid && end_of_set))
        else $error("overflow flag outside the closing result");

    // Fill count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("element count beyond capacity");
`endif

endmodule

// ===== hw/rtl/mse_cell.sv =====
module mse_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,       // unload mode: take the right neighbor's element
    input  mse_pkg::mse_beat_t left_fwd,   // element traveling in from the left
    input  mse_pkg::mse_beat_t right_held, // element held by the right neighbor
    output mse_pkg::mse_beat_t fwd,        // element traveling on to the right
    output mse_pkg::mse_beat_t held        // element kept by this cell
);
    import mse_pkg::*;

    logic                     held_valid_reg;
    logic                     held_valid_next;
    logic signed [DATA_W-1:0] held_data_reg;
    logic signed [DATA_W-1:0] held_data_next;
    logic                     fwd_valid_reg;
    logic                     fwd_valid_next;
    logic signed [DATA_W-1:0] fwd_data_reg;
    logic signed [DATA_W-1:0] fwd_data_next;

    // Keep the smaller element, hand the larger one on (ties hand on the newcomer)
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_data_next  = held_data_reg;
        fwd_valid_next  = 1'b0;
        fwd_data_next   = fwd_data_reg;
        if (shift)
        begin
            held_valid_next = right_held.valid;
            held_data_next  = right_held.data;
        end
        else if (left_fwd.valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_data_next  = left_fwd.data;
            end
            else if (left_fwd.data < held_data_reg)
            begin
                held_data_next = left_fwd.data;
                fwd_valid_next = 1'b1;
                fwd_data_next  = held_data_reg;
            end
            else
            begin
                fwd_valid_next = 1'b1;
                fwd_data_next  = left_fwd.data;
            end
        end
    end

    // Control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        held_data_reg <= held_data_next;
        fwd_data_reg  <= fwd_data_next;
    end

    assign held.valid = held_valid_reg;
    assign held.data  = held_data_reg;
    assign fwd.valid  = fwd_valid_reg;
    assign fwd.data   = fwd_data_reg;

endmodule

// ===== test/merge_sort_engine_unit_test.sv =====
module merge_sort_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam int CAPACITY     = MAX_ELEMENTS_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int NUM_ROWS     = 21;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] ZERO     = '0;
    localparam logic signed [DATA_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflowed;
    } sort_result_t;

    // One directed beat; typed rows carry their own single result
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
        logic                     typed;
        sort_result_t             want;
    } load_row_t;

    typedef enum int {
        VALS_WIDE,
        VALS_TIES,
        VALS_EDGES
    } value_style_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     busy;
    logic                     result_valid;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflowed;

    // Predictor state: elements of the open set and the drop flag
    logic signed [DATA_W-1:0] set_elems[$];
    logic                     set_dropped;
    sort_result_t             sorted_expect[$];

    int mismatch_count;
    int cycle_count;
    int sent_items;
    int calm_left;

    load_row_t directed_rows [NUM_ROWS] = '{
        // single-element sets: the extremes, zero and all ones
        '{MOST_NEG, 1'b1, 1'b1, '{MOST_NEG, 1'b1, 1'b0}},
        '{MOST_POS, 1'b1, 1'b1, '{MOST_POS, 1'b1, 1'b0}},
        '{ZERO,     1'b1, 1'b1, '{ZERO,     1'b1, 1'b0}},
        '{ALL_ONES, 1'b1, 1'b1, '{ALL_ONES, 1'b1, 1'b0}},
        // both extremes in one set, wrong order
        '{MOST_POS, 1'b0, 1'b0, '0},
        '{MOST_NEG, 1'b1, 1'b0, '0},
        // ties
        '{32'sd5,   1'b0, 1'b0, '0},
        '{32'sd5,   1'b0, 1'b0, '0},
        '{-32'sd3,  1'b0, 1'b0, '0},
        '{32'sd5,   1'b1, 1'b0, '0},
        // already ascending
        '{32'sd1,   1'b0, 1'b0, '0},
        '{32'sd2,   1'b0, 1'b0, '0},
        '{32'sd3,   1'b1, 1'b0, '0},
        // descending across zero
        '{32'sd9,   1'b0, 1'b0, '0},
        '{32'sd4,   1'b0, 1'b0, '0},
        '{ZERO,     1'b0, 1'b0, '0},
        '{-32'sd4,  1'b1, 1'b0, '0},
        // alternating bit patterns
        '{32'sh5555_5555, 1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0, '0},
        // sign boundary
        '{ZERO,     1'b0, 1'b0, '0},
        '{ALL_ONES, 1'b1, 1'b0, '0}
    };

    merge_sort_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .value        (value),
        .is_last      (is_last),
        .busy         (busy),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflowed   (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Store a beat; on the closing beat sort stably and queue the results
    task automatic absorb_beat(input logic signed [DATA_W-1:0] v, input logic last);
        logic signed [DATA_W-1:0] ordered[$];
        int                       slot;
        sort_result_t             res;
        if (set_elems.size() < CAPACITY)
            set_elems.push_back(v);
        else
            set_dropped = 1'b1;
        if (last)
        begin
            // insertion after all equal values keeps the left-first order
            foreach (set_elems[j])
            begin
                slot = 0;
                while (slot < ordered.size() && ordered[slot] <= set_elems[j])
                    slot++;
                ordered.insert(slot, set_elems[j]);
            end
            foreach (ordered[k])
            begin
                res.sorted_value = ordered[k];
                res.end_of_set   = (k == ordered.size() - 1);
                res.overflowed   = res.end_of_set & set_dropped;
                sorted_expect.push_back(res);
            end
            set_elems.delete();
            set_dropped = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_element(input logic signed [DATA_W-1:0] v, input logic last);
        int gap;
        int roll;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                calm_left = $urandom_range(10, 30);
            else if (roll < 60)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(20, 90);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        absorb_beat(v, last);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input value_style_t style);
        case (style)
            VALS_TIES:
                return int'($urandom_range(0, 6)) - 3;
            VALS_EDGES:
                case ($urandom_range(0, 4))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return ZERO;
                    3:       return ALL_ONES;
                    default: return $urandom;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        value_style_t style;
        style = value_style_t'($urandom_range(0, 2));
        for (int k = 0; k < n; k++)
            send_element(pick_value(style), k == n - 1);
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge clk)
    begin
        sort_result_t want;
        if (rst_n && result_valid)
        begin
            if (sorted_expect.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", sorted_value));
            else
            begin
                want = sorted_expect.pop_front();
                if (sorted_value !== want.sorted_value || end_of_set !== want.end_of_set
                    || overflowed !== want.overflowed)
                    report_mismatch($sformatf("got %0d/%b/%b, expected %0d/%b/%b",
                        sorted_value, end_of_set, overflowed,
                        want.sorted_value, want.end_of_set, want.overflowed));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int roll;
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        is_last        = 1'b0;
        set_dropped    = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        sent_items     = 0;
        calm_left      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows; a typed row stands in for the predicted result
        foreach (directed_rows[r])
        begin
            send_element(directed_rows[r].value, directed_rows[r].is_last);
            if (directed_rows[r].typed)
            begin
                void'(sorted_expect.pop_back());
                sorted_expect.push_back(directed_rows[r].want);
            end
        end

        // exactly full, full with the closing beat dropped, several dropped
        send_set(CAPACITY);
        send_set(CAPACITY + 1);
        send_set(CAPACITY + 6);

        // random sets, mostly small
        while (sent_items < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                send_set($urandom_range(1, 6));
            else if (roll < 90)
                send_set($urandom_range(7, 40));
            else if (roll < 95)
                send_set(CAPACITY);
            else
                send_set($urandom_range(CAPACITY + 1, CAPACITY + 6));
        end
        start <= 1'b0;

        // drain, then watch for stray beats
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_cell.sv
hw/rtl/merge_sort_engine_unit.sv
test/merge_sort_engine_unit_test.sv
